FILE: design/imabd_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and tables for the ima adpcm block decoder
package imabd_pkg;

  localparam int unsigned FRAME_W      = 14;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned STEP_POS_W   = 7;
  localparam int unsigned STEP_W       = 15;
  localparam int unsigned SAMPLE_W     = 16;

  localparam logic [STEP_POS_W-1:0] MAX_STEP_POS = 7'd88;
  localparam logic [FRAME_W-1:0]    MIN_FRAME    = 14'd2;
  localparam logic [FRAME_W-1:0]    MAX_FRAME    = 14'd8192;
  localparam logic [FRAME_W-1:0]    FRAME_RESET  = 14'd1017;

  localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // what one step of the decoder does with the byte in the input register
  typedef struct packed {
    logic emit;         // a sample goes to the output register
    logic from_header;  // that sample is the header's initial sample
    logic last;         // final sample for this byte
    logic consume;      // the byte is finished with
  } step_info_t;

  function automatic logic [STEP_W-1:0] step_size(input logic [STEP_POS_W-1:0] pos);
    logic [STEP_W-1:0] s;
    if (pos > MAX_STEP_POS) begin
      s = STEP_TABLE[MAX_STEP_POS];
    end else begin
      s = STEP_TABLE[pos];
    end
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

FILE: design/imabd_nibble.sv
`timescale 1ns / 1ps
// one ima adpcm nibble decode: predictor and step index update with saturation
module imabd_nibble (
  input  logic signed [imabd_pkg::SAMPLE_W-1:0]   pred_i,
  input  logic        [imabd_pkg::STEP_POS_W-1:0] step_pos_i,
  input  logic        [3:0]                       code_i,
  output logic signed [imabd_pkg::SAMPLE_W-1:0]   pred_o,
  output logic        [imabd_pkg::STEP_POS_W-1:0] step_pos_o
);

  logic        [imabd_pkg::STEP_W-1:0] step;
  logic        [16:0]                  diff;
  logic signed [17:0]                  pred_ext;
  logic signed [17:0]                  sum;
  logic signed [4:0]                   adj;
  logic signed [8:0]                   pos_sum;

  always_comb begin
    step = imabd_pkg::step_size(step_pos_i);
    diff = {5'b0, step[14:3]}
         + (code_i[2] ? {2'b0, step}       : 17'd0)
         + (code_i[1] ? {3'b0, step[14:1]} : 17'd0)
         + (code_i[0] ? {4'b0, step[14:2]} : 17'd0);
    pred_ext = {{2{pred_i[15]}}, pred_i};
    if (code_i[3]) begin
      sum = pred_ext - $signed({1'b0, diff});
    end else begin
      sum = pred_ext + $signed({1'b0, diff});
    end
    if (sum > 18'sd32767) begin
      pred_o = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      pred_o = 16'sh8000;
    end else begin
      pred_o = sum[15:0];
    end

    adj     = imabd_pkg::index_adjust(code_i[2:0]);
    pos_sum = $signed({2'b0, step_pos_i}) + $signed({{4{adj[4]}}, adj});
    if (pos_sum < 9'sd0) begin
      step_pos_o = '0;
    end else if (pos_sum > $signed({2'b0, imabd_pkg::MAX_STEP_POS})) begin
      step_pos_o = imabd_pkg::MAX_STEP_POS;
    end else begin
      step_pos_o = pos_sum[6:0];
    end
  end

endmodule

FILE: design/imabd_state.sv
`timescale 1ns / 1ps
// frame and header tracking, decoder state and frame length register
module imabd_state (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [imabd_pkg::FRAME_W-1:0]         cfg_wr_data,
  input  logic                                  fire,
  input  logic [7:0]                            code_byte,
  input  logic                                  nib_hi,
  output imabd_pkg::step_info_t                 info,
  output logic signed [imabd_pkg::SAMPLE_W-1:0] sample
);

  typedef enum logic [1:0] {
    HDR_LO,
    HDR_HI,
    HDR_STEP,
    HDR_RSVD
  } hdr_pos_t;

  logic [imabd_pkg::FRAME_W-1:0]         frame_samples_r;
  hdr_pos_t                              hdr_pos_r, hdr_pos_nxt;
  logic [7:0]                            hdr_low_r, hdr_low_nxt;
  logic signed [imabd_pkg::SAMPLE_W-1:0] pred_r, pred_nxt;
  logic [imabd_pkg::STEP_POS_W-1:0]      step_pos_r, step_pos_nxt;
  logic [imabd_pkg::COUNT_W-1:0]         samples_left_r, samples_left_nxt;

  logic [3:0]                            nibble;
  logic signed [imabd_pkg::SAMPLE_W-1:0] nib_pred;
  logic [imabd_pkg::STEP_POS_W-1:0]      nib_pos;
  logic [imabd_pkg::COUNT_W-1:0]         sl_dec;
  logic [imabd_pkg::FRAME_W-1:0]         fs_use;
  logic [imabd_pkg::FRAME_W-1:0]         fs_less_one;
  logic                                  in_header;

  assign nibble = nib_hi ? code_byte[7:4] : code_byte[3:0];

  imabd_nibble u_nibble (
    .pred_i     (pred_r),
    .step_pos_i (step_pos_r),
    .code_i     (nibble),
    .pred_o     (nib_pred),
    .step_pos_o (nib_pos)
  );

  always_comb begin
    sl_dec    = samples_left_r - 13'd1;
    in_header = (samples_left_r == '0);
    if (frame_samples_r < imabd_pkg::MIN_FRAME) begin
      fs_use = imabd_pkg::MIN_FRAME;
    end else if (frame_samples_r > imabd_pkg::MAX_FRAME) begin
      fs_use = imabd_pkg::MAX_FRAME;
    end else begin
      fs_use = frame_samples_r;
    end
    fs_less_one = fs_use - 14'd1;

    hdr_pos_nxt      = hdr_pos_r;
    hdr_low_nxt      = hdr_low_r;
    pred_nxt         = pred_r;
    step_pos_nxt     = step_pos_r;
    samples_left_nxt = samples_left_r;

    if (in_header) begin
      info.emit        = (hdr_pos_r == HDR_RSVD);
      info.from_header = 1'b1;
      info.last        = 1'b1;
      info.consume     = 1'b1;
      sample           = pred_r;
      case (hdr_pos_r)
        HDR_LO: begin
          hdr_low_nxt = code_byte;
          hdr_pos_nxt = HDR_HI;
        end
        HDR_HI: begin
          pred_nxt    = {code_byte, hdr_low_r};
          hdr_pos_nxt = HDR_STEP;
        end
        HDR_STEP: begin
          if (code_byte > {1'b0, imabd_pkg::MAX_STEP_POS}) begin
            step_pos_nxt = imabd_pkg::MAX_STEP_POS;
          end else begin
            step_pos_nxt = code_byte[6:0];
          end
          hdr_pos_nxt = HDR_RSVD;
        end
        default: begin
          // reserved byte ignored, frame count loaded
          samples_left_nxt = fs_less_one[imabd_pkg::COUNT_W-1:0];
          hdr_pos_nxt      = HDR_LO;
        end
      endcase
    end else begin
      info.emit        = 1'b1;
      info.from_header = 1'b0;
      info.last        = nib_hi || (sl_dec == '0);
      info.consume     = info.last;
      sample           = nib_pred;
      pred_nxt         = nib_pred;
      step_pos_nxt     = nib_pos;
      samples_left_nxt = sl_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_samples_r <= imabd_pkg::FRAME_RESET;
      hdr_pos_r       <= HDR_LO;
      hdr_low_r       <= '0;
      pred_r          <= '0;
      step_pos_r      <= '0;
      samples_left_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_samples_r <= cfg_wr_data;
      end
      if (fire) begin
        hdr_pos_r      <= hdr_pos_nxt;
        hdr_low_r      <= hdr_low_nxt;
        pred_r         <= pred_nxt;
        step_pos_r     <= step_pos_nxt;
        samples_left_r <= samples_left_nxt;
      end
    end
  end

  // header clamps and nibble update both keep the index within the table
  a_step_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_pos_r <= imabd_pkg::MAX_STEP_POS)
    else $error("step index beyond table");

  // header sample comes only from the reserved byte and always ends its beat
  a_hdr_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (info.emit && info.from_header) |-> (info.last && hdr_pos_r == HDR_RSVD))
    else $error("header sample outside reserved byte");

endmodule

FILE: design/ima_adpcm_block_decoder_unit.sv
`timescale 1ns / 1ps
// top level: input byte register, output sample register and handshakes
// Decodes an IMA ADPCM 4-bit block stream one byte per input beat. Each
// frame starts with four header bytes (initial sample low and high, step
// index, reserved); the reserved byte yields the initial sample, flagged
// from_header. Data bytes then yield one sample per nibble, low first, until
// the frame length in cfg_wr_data (clamped to 2..8192) is reached, after
// which a leftover high nibble is dropped. One nibble is decoded per clock
// unless a sample is held in a stalled output register, through a single
// decode unit sitting between the input register and the output register;
// a data byte that yields two samples passes it low nibble first, then high.
// The output register lets the next byte be taken while a sample waits.
module ima_adpcm_block_decoder_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [imabd_pkg::FRAME_W-1:0]         cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_compressed_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [imabd_pkg::SAMPLE_W-1:0] out_pcm_sample,
  output logic                                  out_from_header,
  output logic                                  out_last_of_item
);

  logic                                  in_vld_r;
  logic [7:0]                            in_byte_r;
  logic                                  nib_hi_r;
  logic                                  out_valid_r;
  logic signed [imabd_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                  out_hdr_r;
  logic                                  out_last_r;

  imabd_pkg::step_info_t                 info;
  logic signed [imabd_pkg::SAMPLE_W-1:0] sample;
  logic                                  out_free;
  logic                                  fire;
  logic                                  pop;
  logic                                  in_acc;

  imabd_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .code_byte   (in_byte_r),
    .nib_hi      (nib_hi_r),
    .info        (info),
    .sample      (sample)
  );

  assign out_free = !out_valid_r || !out_stall;
  // header bytes with no sample move on regardless of the output side
  assign fire     = in_vld_r && (!info.emit || out_free);
  assign pop      = fire && info.consume;
  assign in_stall = in_vld_r && !pop;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      nib_hi_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_r  <= 1'b1;
        in_byte_r <= in_compressed_byte;
        nib_hi_r  <= 1'b0;
      end else if (pop) begin
        in_vld_r <= 1'b0;
        nib_hi_r <= 1'b0;
      end else if (fire) begin
        nib_hi_r <= 1'b1;
      end

      if (fire && info.emit) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= sample;
        out_hdr_r    <= info.from_header;
        out_last_r   <= info.last;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pcm_sample   = out_sample_r;
  assign out_from_header  = out_hdr_r;
  assign out_last_of_item = out_last_r;

  a_hi_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    nib_hi_r |-> in_vld_r)
    else $error("high nibble pending with empty input register");

  // a sample that is not the last of its byte leaves the high nibble pending
  a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && info.emit && !info.last) |=> (nib_hi_r && in_vld_r))
    else $error("high nibble lost after low nibble");

  a_high_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && nib_hi_r) |-> (pop && info.last))
    else $error("byte kept after high nibble");

endmodule
